@@ src/xmr_pkg.sv @@
// Shared types and constants for the XModem multi-file receiver.
package xmr_pkg;

    // Block geometry
    localparam int unsigned PAYLOAD_BYTES = 128;
    localparam logic [7:0]  POS_PAYLOAD   = 8'd3;
    localparam logic [7:0]  POS_SUM       = 8'(PAYLOAD_BYTES + 3);
    localparam logic [7:0]  POS_MAX       = 8'hFF;

    // Protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;

    // Input op codes carried in tuser
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RETRY_BUDGET = 1'b0;
    localparam logic CFG_FREE_SPACE   = 1'b1;

    // Reply codes
    localparam logic [1:0] RP_NONE = 2'd0;
    localparam logic [1:0] RP_ACK  = 2'd1;
    localparam logic [1:0] RP_NAK  = 2'd2;

    // Payload kinds
    localparam logic [1:0] PK_NONE   = 2'd0;
    localparam logic [1:0] PK_DATA   = 2'd1;
    localparam logic [1:0] PK_HEADER = 2'd2;

    // Block verdicts
    localparam logic [1:0] VD_NONE    = 2'd0;
    localparam logic [1:0] VD_COMMIT  = 2'd1;
    localparam logic [1:0] VD_DISCARD = 2'd2;

    // Session phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RUN     = 3'd1,
        PH_DONE    = 3'd2,
        PH_FAIL    = 3'd3,
        PH_NOSPACE = 3'd4
    } phase_t;

    // Classified command from the front end
    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTE,
        CMD_TIMEOUT,
        CMD_IGNORE
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       last;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [1:0] reply_code;
        logic [7:0] payload_byte;
        logic [1:0] payload_kind;
        logic [1:0] packet_verdict;
        logic       file_start;
        logic       file_end;
        logic [7:0] file_blocks;
        phase_t     session_status;
    } result_t;

    // Status from queue to back end
    typedef struct packed {
        logic valid;
    } qlink_t;

endpackage

@@ src/xmodem_multi_file_receiver.sv @@
// Top level of the XModem multi-file receiver with 8-bit checksum blocks.
//
// Input stream: one transaction per serial event. tuser carries the op (start session,
// received byte or timeout), tdata the byte, tlast marks the last byte of a
// completed read. Output stream: exactly one result transaction per input transaction,
// carrying the reply byte to send, the speculative payload byte (kind in tuser), the
// commit or discard verdict at the end of a read, file start/end markers and the
// session status after the event.
// Configuration: cfg_we writes cfg_data into the retry budget (index 0) or the free
// space in bytes (index 1) at the clock edge; write only while the block is idle.
// Path: with no stalls the input transaction is written into the command queue, then
// popped into the result register, where m_tvalid rises.
// Throughput: one transaction per cycle while the output is not stalled; the block
// checker updates sum, position and sequence checks combinationally for each byte.
// A stalled output holds its result; the command queue (QUEUE_DEPTH entries) keeps
// accepting input until it is full, then tready drops.
// Reset: session idle, expected block 1, retry budget 0, free space 65535, queue empty.
module xmodem_multi_file_receiver #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        s_tlast,   // end_of_read
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] reply_code, [9:2] payload_byte,
                                   // [11:10] packet_verdict, [12] file_start,
                                   // [13] file_end, [21:14] file_blocks,
                                   // [24:22] session_status, [31:25] zero
    output logic [1:0]  m_tuser    // [1:0] payload_kind
);

    logic              push, q_ready, q_valid, q_pop;
    xmr_pkg::item_t    push_item, head_item;
    xmr_pkg::qlink_t   qlink;
    xmr_pkg::result_t  res;

    xmr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .push     (push),
        .item     (push_item)
    );

    xmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    assign qlink.valid = q_valid;

    xmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_in      (qlink),
        .item      (head_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack result fields, highest field first
    assign m_tdata = {7'd0,
                      res.session_status,
                      res.file_blocks,
                      res.file_end,
                      res.file_start,
                      res.packet_verdict,
                      res.payload_byte,
                      res.reply_code};
    assign m_tuser = res.payload_kind;

endmodule

@@ src/xmr_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
module xmr_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] rx_byte
    input  logic [1:0]    s_tuser,   // [1:0] op
    input  logic          s_tlast,   // end_of_read
    input  logic          q_ready,
    output logic          push,
    output xmr_pkg::item_t item
);

    // Accept whenever the queue has a free slot
    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    // Op decode
    always_comb
    begin
        item.data = s_tdata;
        item.last = s_tlast;
        unique case (s_tuser)
            xmr_pkg::OP_START:   item.cmd = xmr_pkg::CMD_START;
            xmr_pkg::OP_BYTE:    item.cmd = xmr_pkg::CMD_BYTE;
            xmr_pkg::OP_TIMEOUT: item.cmd = xmr_pkg::CMD_TIMEOUT;
            default:             item.cmd = xmr_pkg::CMD_IGNORE;
        endcase
    end

endmodule

@@ src/xmr_queue.sv @@
// Short FIFO of classified commands between front and back end.
module xmr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xmr_pkg::item_t  push_item,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output xmr_pkg::item_t  head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xmr_pkg::item_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != CNT_FULL);
    assign valid = (count_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Never pop an empty queue, never push a full one
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> count_reg != CNT_FULL)
        else $error("queue pushed while full");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");

endmodule

@@ src/xmr_back.sv @@
// Back end: block checking, session state and the registered result slot.
module xmr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  xmr_pkg::qlink_t   q_in,
    input  xmr_pkg::item_t    item,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output xmr_pkg::result_t  res
);

    // Configuration
    logic [7:0]  budget_reg;
    logic [15:0] free_reg;

    // Session and per-read state
    xmr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] exp_reg,     exp_next;
    logic [7:0] blocks_reg,  blocks_next;
    logic [7:0] retries_reg, retries_next;
    logic [7:0] pos_reg,     pos_next;
    logic [7:0] sum_reg,     sum_next;
    logic [7:0] lead_reg,    lead_next;
    logic       ok_reg,      ok_next;
    logic [7:0] cap_reg,     cap_next;

    // Output slot
    logic              out_valid_reg, out_valid_next;
    xmr_pkg::result_t  out_reg, out_next;

    // Decode of the current command
    logic        pop;
    logic        running, do_start, do_tmo, do_byte, do_end;
    logic [7:0]  lead;
    logic        ok;
    logic        in_payload, is_eot, blk_good, is_header, fits, have_retry, bad_path;
    logic        accept_hdr, accept_data;
    logic [23:0] need;

    assign pop       = q_in.valid && (!out_valid_reg || res_ready);
    assign q_pop     = pop;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= 8'd0;
            free_reg   <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                xmr_pkg::CFG_RETRY_BUDGET: budget_reg <= cfg_data[7:0];
                xmr_pkg::CFG_FREE_SPACE:   free_reg   <= cfg_data;
                default:                   budget_reg <= budget_reg;
            endcase
        end
    end

    // Block checks for this byte
    always_comb
    begin
        running  = (phase_reg == xmr_pkg::PH_RUN);
        do_start = pop && (item.cmd == xmr_pkg::CMD_START);
        do_tmo   = pop && (item.cmd == xmr_pkg::CMD_TIMEOUT) && running;
        do_byte  = pop && (item.cmd == xmr_pkg::CMD_BYTE) && running;
        do_end   = do_byte && item.last;

        lead = (pos_reg == 8'd0) ? item.data : lead_reg;
        case (pos_reg)
            8'd0:             ok = (item.data == xmr_pkg::CH_SOH);
            8'd1:             ok = ok_reg && (item.data == exp_reg);
            8'd2:             ok = ok_reg && (item.data == ~exp_reg);
            xmr_pkg::POS_SUM: ok = ok_reg && (item.data == sum_reg);
            default:          ok = ok_reg;
        endcase

        in_payload = (pos_reg >= xmr_pkg::POS_PAYLOAD) && (pos_reg < xmr_pkg::POS_SUM);
        is_eot     = (lead == xmr_pkg::CH_EOT);
        blk_good   = ok && (pos_reg == xmr_pkg::POS_SUM) && !is_eot;
        is_header  = (blocks_reg == 8'd0);
        need       = 24'(cap_reg) * 24'(xmr_pkg::PAYLOAD_BYTES);
        fits       = (need <= 24'(free_reg));
        have_retry = (retries_reg != 8'd0);
        bad_path   = do_tmo || (do_end && !is_eot && !blk_good);

        accept_hdr  = do_end && blk_good && is_header && fits;
        accept_data = do_end && blk_good && !is_header;
    end

    // Next-state logic
    always_comb
    begin
        phase_next   = phase_reg;
        exp_next     = exp_reg;
        blocks_next  = blocks_reg;
        retries_next = retries_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        lead_next    = lead_reg;
        ok_next      = ok_reg;
        cap_next     = cap_reg;

        if (do_start)
        begin
            phase_next   = xmr_pkg::PH_RUN;
            exp_next     = 8'd1;
            blocks_next  = 8'd0;
            retries_next = budget_reg;
        end
        else if (bad_path)
        begin
            if (have_retry)
            begin
                retries_next = retries_reg - 8'd1;
            end
            else
            begin
                phase_next = xmr_pkg::PH_FAIL;
            end
        end
        else if (do_end && is_eot)
        begin
            phase_next = xmr_pkg::PH_DONE;
        end
        else if (do_end && blk_good)
        begin
            exp_next = exp_reg + 8'd1;
            if (!is_header)
            begin
                blocks_next = blocks_reg - 8'd1;
            end
            else if (fits)
            begin
                blocks_next = cap_reg;
            end
            else
            begin
                phase_next = xmr_pkg::PH_NOSPACE;
            end
        end

        // Per-read tracking
        if (do_start || do_tmo || do_end)
        begin
            pos_next  = 8'd0;
            sum_next  = 8'd0;
            lead_next = 8'd0;
            ok_next   = 1'b0;
            cap_next  = 8'd0;
        end
        else if (do_byte)
        begin
            pos_next  = (pos_reg == xmr_pkg::POS_MAX) ? pos_reg : pos_reg + 8'd1;
            sum_next  = sum_reg + item.data;
            lead_next = lead;
            ok_next   = ok;
            if (pos_reg == xmr_pkg::POS_PAYLOAD)
            begin
                cap_next = item.data;
            end
        end
    end

    // Result fields
    always_comb
    begin
        out_next                = '0;
        out_next.session_status = phase_next;
        if (do_start)
        begin
            out_next.reply_code = xmr_pkg::RP_NAK;
        end
        else if (bad_path)
        begin
            out_next.reply_code     = have_retry ? xmr_pkg::RP_NAK : xmr_pkg::RP_NONE;
            out_next.packet_verdict = xmr_pkg::VD_DISCARD;
        end
        else if (do_end && is_eot)
        begin
            out_next.reply_code     = xmr_pkg::RP_ACK;
            out_next.packet_verdict = xmr_pkg::VD_DISCARD;
        end
        else if (accept_hdr)
        begin
            out_next.reply_code     = xmr_pkg::RP_ACK;
            out_next.packet_verdict = xmr_pkg::VD_COMMIT;
            out_next.file_start     = 1'b1;
            out_next.file_blocks    = cap_reg;
            out_next.file_end       = (cap_reg == 8'd0);
        end
        else if (accept_data)
        begin
            out_next.reply_code     = xmr_pkg::RP_ACK;
            out_next.packet_verdict = xmr_pkg::VD_COMMIT;
            out_next.file_end       = (blocks_reg == 8'd1);
        end
        else if (do_end)
        begin
            // good header that does not fit
            out_next.packet_verdict = xmr_pkg::VD_DISCARD;
        end

        if (do_byte && in_payload)
        begin
            out_next.payload_byte = item.data;
            out_next.payload_kind = is_header ? xmr_pkg::PK_HEADER : xmr_pkg::PK_DATA;
        end
    end

    // Output slot occupancy
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= xmr_pkg::PH_IDLE;
            exp_reg       <= 8'd1;
            blocks_reg    <= 8'd0;
            retries_reg   <= 8'd0;
            pos_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            lead_reg      <= 8'd0;
            ok_reg        <= 1'b0;
            cap_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            exp_reg       <= exp_next;
            blocks_reg    <= blocks_next;
            retries_reg   <= retries_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            lead_reg      <= lead_next;
            ok_reg        <= ok_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.cmd == xmr_pkg::CMD_START) |=> phase_reg == xmr_pkg::PH_RUN)
        else $error("start did not enter running phase");
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        do_end |=> pos_reg == 8'd0 && sum_reg == 8'd0)
        else $error("read state not cleared at end of read");
    a_start_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.file_start) |->
            (out_reg.packet_verdict == xmr_pkg::VD_COMMIT &&
             out_reg.reply_code == xmr_pkg::RP_ACK))
        else $error("file start without committed block");
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid_reg || res_ready))
        else $error("result slot overwritten");

endmodule

@@ tb/xmodem_multi_file_receiver_tb.sv @@
// Self-checking testbench for the XModem multi-file receiver: block sessions, checks, replies.
module xmodem_multi_file_receiver_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         RANDOM_ITEMS = 1400;

    // Ways a generated block can be broken
    typedef enum int {
        FL_NONE,
        FL_SOH,
        FL_NUMBER,
        FL_COMPLEMENT,
        FL_CHECKSUM,
        FL_SHORT,
        FL_LONG,
        FL_OVERLONG,
        FL_TIMEOUT
    } block_flaw_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] rx;
        logic       last;
    } serial_event_t;

    // DUT signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic [1:0]  s_tuser = 2'd0;    // [1:0] op
    logic        s_tlast = 1'b0;    // end_of_read
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [1:0] reply, [9:2] payload, [11:10] verdict, [12] start,
                                    // [13] end, [21:14] blocks, [24:22] status, [31:25] zero
    logic [1:0]  m_tuser;           // [1:0] payload_kind

    // Receiver model state and registers
    logic [7:0]  budget_reg = 8'd0;
    logic [15:0] space_reg = 16'hFFFF;
    logic [7:0]  next_block_no = 8'd1;
    logic [7:0]  blocks_due = 8'd0;
    logic [7:0]  retry_count = 8'd0;
    logic [7:0]  read_pos = 8'd0;
    logic [7:0]  read_sum = 8'd0;
    logic [7:0]  read_lead = 8'd0;
    logic        read_ok = 1'b0;
    logic [7:0]  read_count = 8'd0;
    xmr_pkg::phase_t phase = xmr_pkg::PH_IDLE;

    // Stimulus and scoreboard bookkeeping
    serial_event_t     serial_events[$];
    xmr_pkg::result_t  session_outputs[$];
    serial_event_t     cur_event;
    xmr_pkg::result_t  predicted;
    xmr_pkg::result_t  observed;
    int            events_queued = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            tx_gap = 0;
    int            rx_gap = 0;
    int            hold_left = 0;
    int            hold_seq = 0;
    int            hold_seen = 0;
    logic          in_taken = 1'b0;
    logic          steady_flow = 1'b0;

    xmodem_multi_file_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 80);
    endfunction

    // Per-read state cleared
    function automatic void restart_read();
        read_pos   = 8'd0;
        read_sum   = 8'd0;
        read_lead  = 8'd0;
        read_ok    = 1'b0;
        read_count = 8'd0;
    endfunction

    // Bad block or timeout: NAK while retries remain, else the session fails
    function automatic logic [1:0] nak_or_abort();
        if (retry_count != 8'd0)
        begin
            retry_count = retry_count - 8'd1;
            return xmr_pkg::RP_NAK;
        end
        phase = xmr_pkg::PH_FAIL;
        return xmr_pkg::RP_NONE;
    endfunction

    // Advance the receiver by one serial event and build its result
    task automatic xmodem_step(input logic [1:0] op, input logic [7:0] b, input logic eor,
                               output xmr_pkg::result_t r);
        logic [7:0]  pos;
        logic [7:0]  lead;
        logic        ok;
        int unsigned need;
        r = '0;
        if (op == xmr_pkg::OP_START)
        begin
            next_block_no = 8'd1;
            blocks_due    = 8'd0;
            retry_count   = budget_reg;
            restart_read();
            phase = xmr_pkg::PH_RUN;
            r.reply_code = xmr_pkg::RP_NAK;
        end
        else if (op == xmr_pkg::OP_TIMEOUT && phase == xmr_pkg::PH_RUN)
        begin
            r.packet_verdict = xmr_pkg::VD_DISCARD;
            restart_read();
            r.reply_code = nak_or_abort();
        end
        else if (op == xmr_pkg::OP_BYTE && phase == xmr_pkg::PH_RUN)
        begin
            pos  = read_pos;
            lead = (pos == 8'd0) ? b : read_lead;
            ok   = read_ok;
            if (pos == 8'd0)
                ok = (b == xmr_pkg::CH_SOH);
            else if (pos == 8'd1)
                ok = ok && (b == next_block_no);
            else if (pos == 8'd2)
                ok = ok && (b == ~next_block_no);
            else if (pos == xmr_pkg::POS_SUM)
                ok = ok && (b == read_sum);
            if (pos == xmr_pkg::POS_PAYLOAD)
                read_count = b;
            if (pos >= xmr_pkg::POS_PAYLOAD && pos < xmr_pkg::POS_SUM)
            begin
                r.payload_byte = b;
                r.payload_kind = (blocks_due == 8'd0) ? xmr_pkg::PK_HEADER : xmr_pkg::PK_DATA;
            end
            read_lead = lead;
            read_ok   = ok;
            read_sum  = read_sum + b;
            if (read_pos != xmr_pkg::POS_MAX)
                read_pos = read_pos + 8'd1;

            // End of read: judge the block
            if (eor)
            begin
                if (lead == xmr_pkg::CH_EOT)
                begin
                    r.reply_code     = xmr_pkg::RP_ACK;
                    r.packet_verdict = xmr_pkg::VD_DISCARD;
                    phase = xmr_pkg::PH_DONE;
                end
                else if (ok && pos == xmr_pkg::POS_SUM)
                begin
                    next_block_no = next_block_no + 8'd1;
                    if (blocks_due == 8'd0)
                    begin
                        need = read_count * xmr_pkg::PAYLOAD_BYTES;
                        if (need > space_reg)
                        begin
                            r.packet_verdict = xmr_pkg::VD_DISCARD;
                            phase = xmr_pkg::PH_NOSPACE;
                        end
                        else
                        begin
                            blocks_due       = read_count;
                            r.reply_code     = xmr_pkg::RP_ACK;
                            r.packet_verdict = xmr_pkg::VD_COMMIT;
                            r.file_start     = 1'b1;
                            r.file_blocks    = read_count;
                            r.file_end       = (read_count == 8'd0);
                        end
                    end
                    else
                    begin
                        blocks_due       = blocks_due - 8'd1;
                        r.reply_code     = xmr_pkg::RP_ACK;
                        r.packet_verdict = xmr_pkg::VD_COMMIT;
                        r.file_end       = (blocks_due == 8'd0);
                    end
                end
                else
                begin
                    r.packet_verdict = xmr_pkg::VD_DISCARD;
                    r.reply_code     = nak_or_abort();
                end
                restart_read();
            end
        end
        r.session_status = phase;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Monitor: predict on each input transaction, check each result transaction
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            in_taken = rst_n && s_tvalid && s_tready;
            if (in_taken)
            begin
                xmodem_step(s_tuser, s_tdata, s_tlast, predicted);
                session_outputs.push_back(predicted);
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (session_outputs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0h",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    predicted = session_outputs.pop_front();
                    observed.reply_code     = m_tdata[1:0];
                    observed.payload_byte   = m_tdata[9:2];
                    observed.packet_verdict = m_tdata[11:10];
                    observed.file_start     = m_tdata[12];
                    observed.file_end       = m_tdata[13];
                    observed.file_blocks    = m_tdata[21:14];
                    observed.session_status = xmr_pkg::phase_t'(m_tdata[24:22]);
                    observed.payload_kind   = m_tuser;
                    check_field("reply_code", 16'(predicted.reply_code),
                                16'(observed.reply_code));
                    check_field("payload_byte", 16'(predicted.payload_byte),
                                16'(observed.payload_byte));
                    check_field("payload_kind", 16'(predicted.payload_kind),
                                16'(observed.payload_kind));
                    check_field("packet_verdict", 16'(predicted.packet_verdict),
                                16'(observed.packet_verdict));
                    check_field("file_start", 16'(predicted.file_start),
                                16'(observed.file_start));
                    check_field("file_end", 16'(predicted.file_end),
                                16'(observed.file_end));
                    check_field("file_blocks", 16'(predicted.file_blocks),
                                16'(observed.file_blocks));
                    check_field("session_status", 16'(predicted.session_status),
                                16'(observed.session_status));
                    check_field("tdata pad", 16'h0000, 16'(m_tdata[31:25]));
                end
            end
        end
    end

    // Driver: next event after a random gap, held until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (serial_events.size() > 0)
            begin
                cur_event = serial_events.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_event.op;
                s_tdata  <= cur_event.rx;
                s_tlast  <= cur_event.last;
                tx_gap = pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    task automatic push_event(input logic [1:0] op, input logic [7:0] rx, input logic last);
        serial_event_t ev_new;
        ev_new.op   = op;
        ev_new.rx   = rx;
        ev_new.last = last;
        serial_events.push_back(ev_new);
        events_queued++;
    endtask

    // Wait until every queued event has produced its result
    task automatic wait_idle();
        do
            @(negedge clk);
        while (results_seen != events_queued);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == xmr_pkg::CFG_RETRY_BUDGET)
            budget_reg = val[7:0];
        else
            space_reg = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One XModem block, optionally broken in some way
    task automatic send_block(input logic [7:0] num, input logic [7:0] first,
                              input block_flaw_t flaw);
        logic [7:0] frame [0:299];
        logic [7:0] sum;
        int         len;
        int         k;
        sum = 8'h00;
        for (k = 0; k < 300; k++)
            frame[k] = 8'($urandom);
        frame[0] = xmr_pkg::CH_SOH;
        frame[1] = num;
        frame[2] = ~num;
        frame[3] = first;
        case (flaw)
            FL_SOH:        frame[0] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(5, 255));
            FL_NUMBER:     frame[1] = num ^ 8'($urandom_range(1, 255));
            FL_COMPLEMENT: frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
            default:       ;
        endcase
        for (k = 0; k < 131; k++)
            sum = sum + frame[k];
        frame[131] = (flaw == FL_CHECKSUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        case (flaw)
            FL_SHORT:    len = $urandom_range(1, 131);
            FL_LONG:     len = 132 + $urandom_range(1, 8);
            FL_OVERLONG: len = $urandom_range(256, 300);
            FL_TIMEOUT:  len = $urandom_range(0, 131);
            default:     len = 132;
        endcase
        for (k = 0; k < len; k++)
            push_event(xmr_pkg::OP_BYTE, frame[k], (flaw != FL_TIMEOUT) && (k == len - 1));
        if (flaw == FL_TIMEOUT)
            push_event(xmr_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom));
    endtask

    // A session: start, header and data blocks with some noise, then EOT if still alive
    task automatic run_session(input block_flaw_t first_flaw, input int first_count);
        int          blk_limit;
        int          blk_sent;
        int          r;
        int          cnt;
        int          extra;
        int          k;
        logic [7:0]  gen_blk;
        logic [7:0]  gen_left;
        logic [7:0]  gen_retries;
        logic        alive;
        logic        hdr;
        block_flaw_t flaw;
        gen_blk     = 8'd1;
        gen_left    = 8'd0;
        gen_retries = budget_reg;
        alive       = 1'b1;
        blk_sent    = 0;
        blk_limit   = $urandom_range(1, 4);
        push_event(xmr_pkg::OP_START, 8'($urandom), 1'($urandom));
        while (alive && blk_sent < blk_limit)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                push_event(OP_UNUSED, 8'($urandom), 1'($urandom));
            end
            else if (r < 7)
            begin
                push_event(xmr_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom));
                if (gen_retries == 8'd0)
                    alive = 1'b0;
                else
                    gen_retries--;
            end
            else if (r < 9)
            begin
                push_event(xmr_pkg::OP_START, 8'($urandom), 1'($urandom));
                gen_blk     = 8'd1;
                gen_left    = 8'd0;
                gen_retries = budget_reg;
            end
            else
            begin
                hdr = (gen_left == 8'd0);
                if (blk_sent == 0)
                    flaw = first_flaw;
                else if ($urandom_range(0, 99) < 85)
                    flaw = FL_NONE;
                else
                    flaw = block_flaw_t'($urandom_range(1, 8));
                // header counts: mostly tiny, some near the space limit, some large
                if (!hdr)
                    cnt = $urandom_range(0, 255);
                else if (blk_sent == 0 && first_count >= 0)
                    cnt = first_count;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        cnt = $urandom_range(0, 3);
                    else if (r < 85)
                        cnt = space_reg / xmr_pkg::PAYLOAD_BYTES + $urandom_range(0, 1);
                    else
                        cnt = $urandom_range(4, 255);
                    if (cnt > 255)
                        cnt = 255;
                end
                send_block(gen_blk, 8'(cnt), flaw);
                blk_sent++;
                if (flaw != FL_NONE)
                begin
                    if (gen_retries == 8'd0)
                        alive = 1'b0;
                    else
                        gen_retries--;
                end
                else
                begin
                    gen_blk++;
                    if (hdr)
                    begin
                        if (cnt * xmr_pkg::PAYLOAD_BYTES > space_reg)
                            alive = 1'b0;
                        else
                            gen_left = 8'(cnt);
                    end
                    else
                    begin
                        gen_left--;
                    end
                end
            end
        end
        if (alive)
        begin
            extra = $urandom_range(0, 2);
            push_event(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT, extra == 0);
            for (k = 1; k <= extra; k++)
                push_event(xmr_pkg::OP_BYTE, 8'($urandom), k == extra);
        end
    endtask

    // Stimulus
    initial
    begin
        int          ph;
        logic [7:0]  budget;
        logic [15:0] space;
        block_flaw_t first_flaw;
        int          first_count;

        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle inputs ignored, unused op, timeout and short read fail with no budget
        push_event(xmr_pkg::OP_BYTE, 8'hFF, 1'b1);
        push_event(xmr_pkg::OP_BYTE, 8'h00, 1'b0);
        push_event(xmr_pkg::OP_TIMEOUT, 8'hA5, 1'b1);
        push_event(OP_UNUSED, 8'hFF, 1'b1);
        push_event(xmr_pkg::OP_START, 8'h00, 1'b0);
        push_event(OP_UNUSED, 8'h5A, 1'b0);
        push_event(xmr_pkg::OP_TIMEOUT, 8'h00, 1'b0);
        push_event(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH, 1'b1);
        push_event(xmr_pkg::OP_START, 8'hFF, 1'b1);
        push_event(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT, 1'b1);
        push_event(xmr_pkg::OP_START, 8'h00, 1'b0);
        push_event(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH, 1'b0);
        push_event(xmr_pkg::OP_BYTE, 8'h01, 1'b1);
        wait_idle();

        // Directed: full budget, no space; NAKs, then a longer EOT read
        write_reg(xmr_pkg::CFG_RETRY_BUDGET, 16'hFFFF);
        write_reg(xmr_pkg::CFG_FREE_SPACE, 16'h0000);
        push_event(xmr_pkg::OP_START, 8'h00, 1'b0);
        push_event(xmr_pkg::OP_BYTE, 8'hFF, 1'b1);
        push_event(xmr_pkg::OP_TIMEOUT, 8'hFF, 1'b0);
        push_event(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT, 1'b0);
        push_event(xmr_pkg::OP_BYTE, 8'h00, 1'b0);
        push_event(xmr_pkg::OP_BYTE, 8'hFF, 1'b1);
        push_event(xmr_pkg::OP_BYTE, 8'h00, 1'b1);
        wait_idle();

        // Random sessions, each under its own register setting
        events_queued = 0;
        results_seen  = 0;
        ph = 0;
        while (events_queued < RANDOM_ITEMS)
        begin
            first_flaw  = FL_NONE;
            first_count = -1;
            case (ph)
                0:
                begin
                    budget      = 8'd255;
                    space       = 16'hFFFF;
                    first_flaw  = FL_OVERLONG;
                    first_count = 2;
                end
                1:
                begin
                    budget      = 8'd0;
                    space       = 16'h0000;
                    first_count = 0;
                end
                2:
                begin
                    budget      = 8'd1;
                    space       = 16'd128;
                    first_count = 2;
                end
                3:
                begin
                    budget      = 8'd2;
                    space       = 16'd384;
                    first_flaw  = FL_CHECKSUM;
                    first_count = 3;
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       budget = 8'd0;
                        1:       budget = 8'd1;
                        2:       budget = 8'd2;
                        3:       budget = 8'd255;
                        default: budget = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       space = 16'd0;
                        1:       space = 16'd128;
                        2:       space = 16'd383;
                        3:       space = 16'd384;
                        4:       space = 16'hFFFF;
                        default: space = 16'($urandom);
                    endcase
                end
            endcase
            write_reg(xmr_pkg::CFG_RETRY_BUDGET, {8'($urandom), budget});
            write_reg(xmr_pkg::CFG_FREE_SPACE, space);
            steady_flow = (ph % 5 == 4);
            // long output hold-off while the sender keeps offering
            if (ph == 0 || ($urandom_range(0, 9) == 0))
                hold_seq++;
            run_session(first_flaw, first_count);
            wait_idle();
            ph++;
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && session_outputs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
src/xmr_pkg.sv
src/xmr_front.sv
src/xmr_queue.sv
src/xmr_back.sv
src/xmodem_multi_file_receiver.sv
tb/xmodem_multi_file_receiver_tb.sv
